>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check at every edge outside of reset
`define DSSM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dssm assertion failed");

// check at every edge, reset included
`define DSSM_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dssm assertion failed during reset");

`else

`define DSSM_ASSERT(lbl, clk, rstn, prop)
`define DSSM_ASSERT_RST(lbl, clk, prop)

`endif

`endif

>>> rtl/dssm_pkg.sv
// ----------------------------------------------------------------------------
// dssm_pkg
// Types and constants of the two-stack shared memory.
// ----------------------------------------------------------------------------
package dssm_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned FRONT_Q_DEPTH = 2;
  localparam int unsigned RES_Q_DEPTH   = 4;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_DUMP = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_DUMP = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]              command;
    logic                    stack_select;
    logic signed [DataW-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] data_value;
    logic                    last_of_run;
  } res_t;

  typedef struct packed {
    op_e                     op;
    logic                    sel;
    logic signed [DataW-1:0] value;
  } op_t;

endpackage

>>> rtl/dssm_fifo.sv
// ----------------------------------------------------------------------------
// dssm_fifo
// Small register queue with push/full and pop/empty sides and a fill level.
// ----------------------------------------------------------------------------
module dssm_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [Width-1:0]             wdata_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [Width-1:0]             rdata_o,
  output logic                         empty_o,
  output logic [$clog2(Depth+1)-1:0]   level_o
);

  localparam int unsigned PW = $clog2(Depth);
  localparam int unsigned LW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [LW-1:0]    level_q, level_d;
  logic             do_push, do_pop;

  assign full_o  = (level_q == LW'(Depth));
  assign empty_o = (level_q == '0);
  assign level_o = level_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    level_d = level_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (do_pop && !do_push) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/dssm_front.sv
// ----------------------------------------------------------------------------
// dssm_front
// Accepts commands, decodes them into operations and queues them for the
// execution side; the reserved command code is accepted and dropped.
// ----------------------------------------------------------------------------
module dssm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dssm_pkg::cmd_t    cmd_i,
  output logic              full_o,
  output logic              item_vld_o,
  output dssm_pkg::op_t     item_o,
  input  logic              item_take_i
);

  localparam int unsigned OpW = $bits(dssm_pkg::op_t);

  dssm_pkg::op_t  op_in;
  logic           cmd_ok;
  logic [OpW-1:0] q_rdata;
  logic           q_empty;

  always_comb begin
    op_in.sel   = cmd_i.stack_select;
    op_in.value = cmd_i.push_value;
    op_in.op    = dssm_pkg::OP_PUSH;
    cmd_ok      = 1'b1;
    case (cmd_i.command)
      dssm_pkg::CMD_PUSH: op_in.op = dssm_pkg::OP_PUSH;
      dssm_pkg::CMD_POP:  op_in.op = dssm_pkg::OP_POP;
      dssm_pkg::CMD_DUMP: op_in.op = dssm_pkg::OP_DUMP;
      default:            cmd_ok   = 1'b0;
    endcase
  end

  dssm_fifo #(
    .Depth (dssm_pkg::FRONT_Q_DEPTH),
    .Width (OpW)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && cmd_ok),
    .wdata_i (OpW'(op_in)),
    .full_o  (full_o),
    .pop_i   (item_take_i),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .level_o ()
  );

  assign item_vld_o = !q_empty;
  assign item_o     = dssm_pkg::op_t'(q_rdata);

endmodule

>>> rtl/dssm_back.sv
// ----------------------------------------------------------------------------
// dssm_back
// Executes queued operations on the shared entry memory and the two stack
// counts, and feeds results into the result queue under credit control.
// ----------------------------------------------------------------------------
module dssm_back #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          item_vld_i,
  input  dssm_pkg::op_t                                 item_i,
  output logic                                          item_take_o,
  input  logic [$clog2(dssm_pkg::RES_Q_DEPTH+1)-1:0]    res_level_i,
  output logic                                          res_push_o,
  output dssm_pkg::res_t                                res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = $clog2(dssm_pkg::RES_Q_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic [dssm_pkg::DataW-1:0] mem_q [DEPTH];
  logic [dssm_pkg::DataW-1:0] rdata_q;

  logic          state_q, state_d;
  logic [CW-1:0] low_cnt_q, low_cnt_d;
  logic [CW-1:0] high_cnt_q, high_cnt_d;
  logic          sel_q, sel_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] n_q, n_d;
  logic          rd_vld_q, rd_vld_d;
  logic          rd_last_q, rd_last_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] cur_cnt, cnt_dec, cnt_inc;
  logic [CW:0]   total;
  logic          room, dump_last;

  assign cur_cnt   = item_i.sel ? high_cnt_q : low_cnt_q;
  assign cnt_dec   = cur_cnt - 1'b1;
  assign cnt_inc   = cur_cnt + 1'b1;
  assign total     = {1'b0, low_cnt_q} + {1'b0, high_cnt_q};
  assign room      = ({1'b0, res_level_i} + (LW+1)'(rd_vld_q)) < (LW+1)'(dssm_pkg::RES_Q_DEPTH);
  assign dump_last = ((CW'(idx_q) + 1'b1) == n_q);

  always_comb begin
    state_d     = state_q;
    low_cnt_d   = low_cnt_q;
    high_cnt_d  = high_cnt_q;
    sel_d       = sel_q;
    idx_d       = idx_q;
    n_d         = n_q;
    rd_last_d   = rd_last_q;
    re          = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    raddr       = '0;
    item_take_o = 1'b0;

    res_push_o        = rd_vld_q;
    res_o.status      = dssm_pkg::ST_OK;
    res_o.data_value  = rd_vld_q ? rdata_q : '0;
    res_o.last_of_run = rd_vld_q ? rd_last_q : 1'b1;

    case (state_q)
      S_IDLE: begin
        if (item_vld_i && !rd_vld_q && room) begin
          item_take_o = 1'b1;
          case (item_i.op)
            dssm_pkg::OP_PUSH: begin
              res_push_o = 1'b1;
              if (total < (CW+1)'(DEPTH)) begin
                we    = 1'b1;
                waddr = item_i.sel ? LastIdx - cur_cnt[AW-1:0] : cur_cnt[AW-1:0];
                if (item_i.sel) begin
                  high_cnt_d = cnt_inc;
                end else begin
                  low_cnt_d = cnt_inc;
                end
              end else begin
                res_o.status = dssm_pkg::ST_OVERFLOW;
              end
            end
            dssm_pkg::OP_POP: begin
              if (cur_cnt == '0) begin
                res_push_o   = 1'b1;
                res_o.status = dssm_pkg::ST_UNDERFLOW;
              end else begin
                re        = 1'b1;
                raddr     = item_i.sel ? LastIdx - cnt_dec[AW-1:0] : cnt_dec[AW-1:0];
                rd_last_d = 1'b1;
                if (item_i.sel) begin
                  high_cnt_d = cnt_dec;
                end else begin
                  low_cnt_d = cnt_dec;
                end
              end
            end
            dssm_pkg::OP_DUMP: begin
              if (cur_cnt == '0) begin
                res_push_o   = 1'b1;
                res_o.status = dssm_pkg::ST_UNDERFLOW;
              end else begin
                state_d = S_DUMP;
                sel_d   = item_i.sel;
                n_d     = cur_cnt;
                idx_d   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        if (room) begin
          re        = 1'b1;
          raddr     = sel_q ? LastIdx - idx_q : idx_q;
          rd_last_d = dump_last;
          idx_d     = idx_q + 1'b1;
          if (dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rd_vld_d = re;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      low_cnt_q  <= '0;
      high_cnt_q <= '0;
      sel_q      <= 1'b0;
      idx_q      <= '0;
      n_q        <= '0;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      low_cnt_q  <= low_cnt_d;
      high_cnt_q <= high_cnt_d;
      sel_q      <= sel_d;
      idx_q      <= idx_d;
      n_q        <= n_d;
      rd_vld_q   <= rd_vld_d;
      rd_last_q  <= rd_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= item_i.value;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

endmodule

>>> rtl/dual_stack_shared_memory.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_memory
// Two LIFO stacks in one entry memory: the low stack grows up from entry 0,
// the high stack grows down from the top entry.
// ----------------------------------------------------------------------------
// Commands enter through a queue port: an item transfers on a clock edge with
// push high and full low. Results leave through a queue port: the oldest one
// sits on result_o while empty is low and transfers on an edge with pop high.
// A push, a failed pop or a failed dump gives its result straight from the
// execution unit, and the result queue registers it; a pop first reads the
// memory into a register, and a dump first enters its dump state.
// Pushes run at one per cycle while the result queue has room. A pop holds
// off the next command until its registered memory read has given its
// result. A dump of N entries emits one entry per cycle while the result
// queue has room and holds later commands in the command queue meanwhile.
// The reserved command code is accepted and gives no result.
// A full result queue stalls execution; the command queue then fills and full
// rises. Reset empties both queues and both stacks; memory contents are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_stack_shared_memory #(
  parameter int unsigned DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  input  dssm_pkg::cmd_t  item_i,
  output logic            full,
  output logic            empty,
  input  logic            pop,
  output dssm_pkg::res_t  result_o
);

  localparam int unsigned ResW = $bits(dssm_pkg::res_t);
  localparam int unsigned LW   = $clog2(dssm_pkg::RES_Q_DEPTH + 1);

  logic            item_vld;
  logic            item_take;
  dssm_pkg::op_t   item;
  logic            res_push;
  dssm_pkg::res_t  res_in;
  logic            res_full;
  logic [LW-1:0]   res_level;
  logic [ResW-1:0] res_rdata;
  logic            res_err;
  logic            res_err_clean;

  dssm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (item_i),
    .full_o      (full),
    .item_vld_o  (item_vld),
    .item_o      (item),
    .item_take_i (item_take)
  );

  dssm_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_vld_i  (item_vld),
    .item_i      (item),
    .item_take_o (item_take),
    .res_level_i (res_level),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  dssm_fifo #(
    .Depth (dssm_pkg::RES_Q_DEPTH),
    .Width (ResW)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (ResW'(res_in)),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty),
    .level_o (res_level)
  );

  assign result_o = dssm_pkg::res_t'(res_rdata);

  assign res_err       = res_push && (res_in.status != dssm_pkg::ST_OK);
  assign res_err_clean = (res_in.data_value == '0) && res_in.last_of_run;

  `DSSM_ASSERT(a_full_vld, clk_i, rst_ni, full |-> item_vld)
  `DSSM_ASSERT(a_res_credit, clk_i, rst_ni, res_push |-> !res_full)
  `DSSM_ASSERT(a_take_vld, clk_i, rst_ni, item_take |-> item_vld)
  `DSSM_ASSERT(a_err_zero, clk_i, rst_ni, res_err |-> res_err_clean)

endmodule
